[rtl/assert_macros.svh]
// assertion helpers for the rtl, included by the realizer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HH_ASSERT(lbl, clk, rst, prop, msg)
`define HH_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/hhgr_pkg.sv]
package hhgr_pkg;

   localparam int DEG_W            = 6;
   localparam int LAB_W            = 5;
   localparam int ROW_W            = 32;
   localparam int CNT_W            = 6;
   localparam int KEY_W            = DEG_W + LAB_W;
   localparam int MAX_VERTICES_DEF = 32;
   localparam int STORE_DEPTH      = 32;

   typedef enum logic [2:0] {
      OP_HOLD  = 3'd0,
      OP_LOAD  = 3'd1,
      OP_INIT  = 3'd2,
      OP_PREP  = 3'd3,
      OP_SORT  = 3'd4,
      OP_OSORT = 3'd5,
      OP_JOIN  = 3'd6,
      OP_SHIFT = 3'd7
   } cell_op_type;

   typedef struct packed {
      logic             valid;
      logic [DEG_W-1:0] deg;
      logic [LAB_W-1:0] lab;
      logic [LAB_W-1:0] pos;
      logic [ROW_W-1:0] row;
   } entry_type;

   typedef struct packed {
      cell_op_type      op;
      logic [CNT_W-1:0] addr;
      logic [DEG_W-1:0] degree;
      logic [CNT_W-1:0] count;
      logic             phase;
      logic [DEG_W-1:0] join_k;
      logic [LAB_W-1:0] lab0;
      logic [ROW_W-1:0] mask;
   } cmd_type;

endpackage

[rtl/hhgr_cell.sv]
module hhgr_cell
   import hhgr_pkg::*;
#(
   parameter int IDX   = 0,
   parameter bit HAS_L = 1'b1,
   parameter bit HAS_R = 1'b1
) (
   input  logic      clock,
   input  cmd_type   cmd,
   input  entry_type left_entry,
   input  entry_type right_entry,
   output entry_type entry
);

   entry_type entry_ff, entry_in;
   logic      by_label;
   logic      pair_right;

   function automatic logic [KEY_W-1:0] order_key(entry_type e, logic lbl);
      // larger key goes toward cell 0
      if (lbl) return KEY_W'({e.valid, ~e.lab});
      else     return {e.deg, e.pos};
   endfunction

   always_comb begin
      entry_in   = entry_ff;
      by_label   = (cmd.op == OP_OSORT);
      pair_right = (1'(IDX % 2) == cmd.phase);
      case (cmd.op)
         OP_LOAD: begin
            if (cmd.addr == CNT_W'(IDX)) begin
               entry_in.deg = cmd.degree;
               entry_in.lab = LAB_W'(IDX);
            end
         end
         OP_INIT: begin
            entry_in.valid = (CNT_W'(IDX) < cmd.count);
            if (!(CNT_W'(IDX) < cmd.count)) entry_in.deg = '0;
            // unused slots get a known label so the label sort stays defined
            entry_in.lab = LAB_W'(IDX);
            entry_in.row = '0;
         end
         OP_PREP: entry_in.pos = LAB_W'(IDX);
         OP_SORT, OP_OSORT: begin
            if (pair_right) begin
               if (HAS_R && order_key(right_entry, by_label) > order_key(entry_ff, by_label))
                  entry_in = right_entry;
            end else begin
               if (HAS_L && order_key(entry_ff, by_label) > order_key(left_entry, by_label))
                  entry_in = left_entry;
            end
         end
         OP_JOIN: begin
            if (IDX == 0) begin
               entry_in.deg = '0;
               entry_in.row = entry_ff.row | cmd.mask;
            end else if (CNT_W'(IDX) <= cmd.join_k) begin
               entry_in.deg = entry_ff.deg - DEG_W'(1);
               entry_in.row = entry_ff.row | (ROW_W'(1) << cmd.lab0);
            end
         end
         OP_SHIFT: if (HAS_R) entry_in = right_entry;
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[rtl/havel_hakimi_graph_realizer.sv]
// Havel-Hakimi graph realizer.
// req channel: one beat per vertex degree, tlast on the final vertex. Vertices are
// numbered in arrival order. Loading takes one beat per cycle.
// The final beat starts realization in a row of NC cells (NC is MAX_VERTICES, at
// most 32), one per vertex. After an init step, each round is a prep step, an
// odd-even transposition sort and a check/join step; a sequence of n vertices
// needs at most n + 1 rounds, and a final label sort follows. req_tready is low
// for all of that time.
// rsp channel: one beat per vertex row in vertex order, ok set, tlast on the last
// row; an invalid sequence or one longer than the limit gives a single beat with
// ok clear and tlast set. A stalled rsp beat holds; the row shifts only on accept.
// After the last rsp beat the block takes a new sequence.
// reset: synchronous, returns to loading with no vertices held.
module havel_hakimi_graph_realizer
   import hhgr_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [5:0] degree
   input  logic        req_tlast,   // last_vertex
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [4:0] row_index, [36:5] row_bits, [37] ok
   output logic        rsp_tlast    // last
);

`include "assert_macros.svh"

   localparam int NC = (MAX_VERTICES < STORE_DEPTH) ? MAX_VERTICES : STORE_DEPTH;
   localparam int IW = $clog2(NC);
   localparam int SW = $clog2(NC + 1);

   typedef enum logic [6:0] {
      ST_LOAD  = 7'b0000001,
      ST_INIT  = 7'b0000010,
      ST_PREP  = 7'b0000100,
      ST_SORT  = 7'b0001000,
      ST_CHECK = 7'b0010000,
      ST_OSORT = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic             fail_ff, fail_in;
   logic [CNT_W-1:0] vc_ff, vc_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SW-1:0]    sort_cnt_ff, sort_cnt_in;
   logic [CNT_W-1:0] emit_ff, emit_in;

   entry_type        cells [NC];
   cmd_type          cmd;
   logic             req_acc, rsp_acc, stored, sort_done, do_join, emit_last;
   logic [DEG_W-1:0] deg0;
   logic [ROW_W-1:0] mask;

   genvar gi;
   generate
      for (gi = 0; gi < NC; gi++) begin : g_cell
         hhgr_cell #(
            .IDX   (gi),
            .HAS_L (gi != 0),
            .HAS_R (gi != NC - 1)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .left_entry  (cells[(gi == 0) ? 0 : gi - 1]),
            .right_entry (cells[(gi == NC - 1) ? gi : gi + 1]),
            .entry       (cells[gi])
         );
      end
   endgenerate

   assign deg0 = cells[0].deg;

   always_comb begin
      mask = '0;
      for (int i = 1; i < NC; i++) begin
         if (CNT_W'(i) <= deg0) mask = mask | (ROW_W'(1) << cells[i].lab);
      end
   end

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign stored     = (vc_ff < CNT_W'(NC));
   assign sort_done  = (sort_cnt_ff == SW'(NC - 1));
   assign emit_last  = fail_ff || (emit_ff == count_ff - CNT_W'(1));
   // sorted descending, so more than maxd vertices left iff cell maxd is nonzero
   assign do_join    = (deg0 != '0) && (deg0 < DEG_W'(NC)) &&
                       (cells[deg0[IW-1:0]].deg != '0);

   always_comb begin
      cmd        = '0;
      cmd.op     = OP_HOLD;
      cmd.addr   = vc_ff;
      cmd.degree = req_tdata[5:0];
      cmd.count  = count_ff;
      cmd.phase  = sort_cnt_ff[0];
      cmd.join_k = deg0;
      cmd.lab0   = cells[0].lab;
      cmd.mask   = mask;
      case (state_ff)
         ST_LOAD:  if (req_acc && stored) cmd.op = OP_LOAD;
         ST_INIT:  cmd.op = OP_INIT;
         ST_PREP:  cmd.op = OP_PREP;
         ST_SORT:  cmd.op = OP_SORT;
         ST_CHECK: if (do_join) cmd.op = OP_JOIN;
         ST_OSORT: cmd.op = OP_OSORT;
         ST_EMIT:  if (rsp_acc && !fail_ff) cmd.op = OP_SHIFT;
         default:  cmd.op = OP_HOLD;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      fail_in     = fail_ff;
      vc_in       = vc_ff;
      ovf_in      = ovf_ff;
      count_in    = count_ff;
      sort_cnt_in = sort_cnt_ff;
      emit_in     = emit_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (stored) vc_in = vc_ff + CNT_W'(1);
               else        ovf_in = 1'b1;
               if (req_tlast) begin
                  count_in = stored ? vc_ff + CNT_W'(1) : vc_ff;
                  fail_in  = ovf_ff || !stored;
                  vc_in    = '0;
                  ovf_in   = 1'b0;
                  emit_in  = '0;
                  state_in = (ovf_ff || !stored) ? ST_EMIT : ST_INIT;
               end
            end
         end
         ST_INIT: state_in = ST_PREP;
         ST_PREP: begin
            sort_cnt_in = '0;
            state_in    = ST_SORT;
         end
         ST_SORT: begin
            sort_cnt_in = sort_cnt_ff + SW'(1);
            if (sort_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            sort_cnt_in = '0;
            if (deg0 == '0)   state_in = ST_OSORT;
            else if (do_join) state_in = ST_PREP;
            else begin
               fail_in  = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_OSORT: begin
            sort_cnt_in = sort_cnt_ff + SW'(1);
            if (sort_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               emit_in = emit_ff + CNT_W'(1);
               if (emit_last) state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         fail_ff  <= 1'b0;
         vc_ff    <= '0;
         ovf_ff   <= 1'b0;
         count_ff <= '0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fail_ff  <= fail_in;
         vc_ff    <= vc_in;
         ovf_ff   <= ovf_in;
         count_ff <= count_in;
         emit_ff  <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      sort_cnt_ff <= sort_cnt_in;
   end

   assign rsp_tdata = fail_ff ? 40'd0
                              : {2'b00, 1'b1, cells[0].row, emit_ff[LAB_W-1:0]};
   assign rsp_tlast = emit_last;

   `HH_ASSERT(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid), "load and emit overlap")
   `HH_ASSERT(a_vc_range, clock, reset, vc_ff <= CNT_W'(NC), "vertex count past limit")
   `HH_ASSERT(a_emit_range, clock, reset, (rsp_tvalid && !fail_ff) |-> (emit_ff < count_ff), "row beyond count")
   `HH_ASSERT(a_busy_after_last, clock, reset, (req_acc && req_tlast) |=> !req_tready, "took beat after last")

endmodule
